@@ rtl/mqbr_pkg.sv @@
package mqbr_pkg;

  // Sizing of the ring set.
  localparam int NUM_QUEUES  = 32;
  localparam int QUEUE_BYTES = 4096;
  localparam int MAX_POP     = 64;

  // Field widths of the item and result ports.
  localparam int ACT_W  = 2;
  localparam int EP_W   = 5;
  localparam int BYTE_W = 8;
  localparam int REQ_W  = 7;
  localparam int STAT_W = 3;

  // Derived internal widths.
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W  = $clog2(QUEUE_BYTES);
  localparam int FILL_W = $clog2(QUEUE_BYTES + 1);
  localparam int CNT_W  = $clog2(MAX_POP + 1);
  localparam int ADDR_W = QIDX_W + PTR_W;
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_BYTES;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_OPEN  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLOSE = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOFREE  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted item
    logic do_single;  // execute a one-result action and emit its result
    logic pop_start;  // load the pop byte count, first byte read under way
    logic pop_step;   // emit one popped byte and advance the tail
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_go;    // held item is a pop on a valid, non-empty queue
    logic pop_last;  // one byte of the current pop remains
    logic out_free;  // the output register can take a result this cycle
  } stat_t;

endpackage

@@ rtl/mqbr_ctrl.sv @@
module mqbr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  mqbr_pkg::stat_t stat,
  output mqbr_pkg::cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign item_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.load      = item_valid && item_ready;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.pop_go) begin
          cmd.pop_start = 1'b1;
          state_next    = S_POP;
        end else if (stat.out_free) begin
          cmd.do_single = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_POP: begin
        if (stat.out_free) begin
          cmd.pop_step = 1'b1;
          if (stat.pop_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/mqbr_dp.sv @@
module mqbr_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  mqbr_pkg::cmd_t                cmd,
  output mqbr_pkg::stat_t               stat,
  input  logic [mqbr_pkg::ACT_W-1:0]    action,
  input  logic [mqbr_pkg::EP_W-1:0]     endpoint,
  input  logic [mqbr_pkg::BYTE_W-1:0]   data_in,
  input  logic [mqbr_pkg::REQ_W-1:0]    request_len,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [mqbr_pkg::BYTE_W-1:0]   data_out,
  output logic [mqbr_pkg::STAT_W-1:0]   status,
  output logic [mqbr_pkg::EP_W-1:0]     endpoint_out,
  output logic [mqbr_pkg::FILL_W-1:0]   level,
  output logic                          last
);

  // Captured item.
  logic [mqbr_pkg::ACT_W-1:0]  act_q;
  logic [mqbr_pkg::EP_W-1:0]   ep_q;
  logic [mqbr_pkg::BYTE_W-1:0] din_q;
  logic [mqbr_pkg::REQ_W-1:0]  req_q;

  // Per-queue control state.
  logic                         in_use   [mqbr_pkg::NUM_QUEUES];
  logic [mqbr_pkg::PTR_W-1:0]   head_ptr [mqbr_pkg::NUM_QUEUES];
  logic [mqbr_pkg::PTR_W-1:0]   tail_ptr [mqbr_pkg::NUM_QUEUES];
  logic [mqbr_pkg::FILL_W-1:0]  fill_cnt [mqbr_pkg::NUM_QUEUES];

  // Byte storage, one ring per queue, registered read.
  logic [mqbr_pkg::BYTE_W-1:0]  byte_mem [mqbr_pkg::MEM_DEPTH];
  logic [mqbr_pkg::BYTE_W-1:0]  rd_data;
  logic [mqbr_pkg::ADDR_W-1:0]  rd_addr;
  logic                         wr_en;

  // Lowest free queue, registered.
  logic [mqbr_pkg::QIDX_W-1:0]  free_idx;
  logic                         free_any;
  logic [mqbr_pkg::QIDX_W-1:0]  free_idx_next;
  logic                         free_any_next;

  logic [mqbr_pkg::CNT_W-1:0]   remain;

  // Selected queue.
  logic [mqbr_pkg::QIDX_W-1:0]  qi;
  logic                         cur_used;
  logic [mqbr_pkg::PTR_W-1:0]   cur_head;
  logic [mqbr_pkg::PTR_W-1:0]   cur_tail;
  logic [mqbr_pkg::FILL_W-1:0]  cur_fill;
  logic [mqbr_pkg::PTR_W-1:0]   head_adv;
  logic [mqbr_pkg::PTR_W-1:0]   tail_adv;
  logic                         ep_valid;
  logic [mqbr_pkg::CNT_W-1:0]   req_clamp;
  logic [mqbr_pkg::CNT_W-1:0]   pop_n;

  // Queue state update, one queue per cycle.
  logic                         q_we;
  logic [mqbr_pkg::QIDX_W-1:0]  q_idx;
  logic                         q_used;
  logic [mqbr_pkg::PTR_W-1:0]   q_head;
  logic [mqbr_pkg::PTR_W-1:0]   q_tail;
  logic [mqbr_pkg::FILL_W-1:0]  q_fill;

  // Result to load into the output register.
  logic                          emit;
  logic [mqbr_pkg::BYTE_W-1:0]   e_data;
  logic [mqbr_pkg::STAT_W-1:0]   e_status;
  logic [mqbr_pkg::EP_W-1:0]     e_ep;
  logic [mqbr_pkg::FILL_W-1:0]   e_level;
  logic                          e_last;

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= action;
      ep_q  <= endpoint;
      din_q <= data_in;
      req_q <= request_len;
    end
  end

  // Look up the addressed queue.
  assign qi       = ep_q[mqbr_pkg::QIDX_W-1:0];
  assign cur_used = in_use[qi];
  assign cur_head = head_ptr[qi];
  assign cur_tail = tail_ptr[qi];
  assign cur_fill = fill_cnt[qi];
  assign ep_valid = (32'(ep_q) < mqbr_pkg::NUM_QUEUES) && cur_used;

  assign head_adv = (cur_head == mqbr_pkg::PTR_W'(mqbr_pkg::QUEUE_BYTES - 1)) ?
                    '0 : cur_head + 1'b1;
  assign tail_adv = (cur_tail == mqbr_pkg::PTR_W'(mqbr_pkg::QUEUE_BYTES - 1)) ?
                    '0 : cur_tail + 1'b1;

  // Pop length: zero acts as one, anything above the limit is cut to it.
  always_comb begin
    if (req_q == '0) begin
      req_clamp = mqbr_pkg::CNT_W'(1);
    end else if (32'(req_q) > mqbr_pkg::MAX_POP) begin
      req_clamp = mqbr_pkg::CNT_W'(mqbr_pkg::MAX_POP);
    end else begin
      req_clamp = mqbr_pkg::CNT_W'(req_q);
    end
  end

  assign pop_n = (mqbr_pkg::FILL_W'(req_clamp) < cur_fill) ?
                 req_clamp : mqbr_pkg::CNT_W'(cur_fill);

  // Status toward the controller.
  assign stat.pop_go   = (act_q == mqbr_pkg::ACT_POP) && ep_valid && (cur_fill != '0);
  assign stat.pop_last = (remain == mqbr_pkg::CNT_W'(1));
  assign stat.out_free = !result_valid || result_ready;

  // Lowest free queue search over the in-use marks.
  always_comb begin
    free_idx_next = '0;
    free_any_next = 1'b0;
    for (int i = mqbr_pkg::NUM_QUEUES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_idx_next = mqbr_pkg::QIDX_W'(i);
        free_any_next = 1'b1;
      end
    end
  end

  // Action execution: queue update, memory access and result.
  always_comb begin
    q_we     = 1'b0;
    q_idx    = qi;
    q_used   = cur_used;
    q_head   = cur_head;
    q_tail   = cur_tail;
    q_fill   = cur_fill;
    wr_en    = 1'b0;
    rd_addr  = {qi, cur_tail};
    emit     = 1'b0;
    e_data   = '0;
    e_status = mqbr_pkg::ST_OK;
    e_ep     = ep_q;
    e_level  = '0;
    e_last   = 1'b1;

    if (cmd.do_single) begin
      emit = 1'b1;
      if (act_q == mqbr_pkg::ACT_OPEN) begin
        if (free_any) begin
          q_we   = 1'b1;
          q_idx  = free_idx;
          q_used = 1'b1;
          q_head = '0;
          q_tail = '0;
          q_fill = '0;
          e_ep   = mqbr_pkg::EP_W'(free_idx);
        end else begin
          e_status = mqbr_pkg::ST_NOFREE;
        end
      end else if (!ep_valid) begin
        e_status = mqbr_pkg::ST_INVALID;
      end else begin
        unique case (act_q)
          mqbr_pkg::ACT_PUSH: begin
            if (cur_fill >= mqbr_pkg::FILL_W'(mqbr_pkg::QUEUE_BYTES)) begin
              e_status = mqbr_pkg::ST_FULL;
              e_level  = cur_fill;
            end else begin
              wr_en   = 1'b1;
              q_we    = 1'b1;
              q_head  = head_adv;
              q_fill  = cur_fill + 1'b1;
              e_level = cur_fill + 1'b1;
            end
          end
          mqbr_pkg::ACT_CLOSE: begin
            q_we   = 1'b1;
            q_used = 1'b0;
            q_head = '0;
            q_tail = '0;
            q_fill = '0;
          end
          // A pop reaches here only on an empty queue.
          default: begin
            e_status = mqbr_pkg::ST_EMPTY;
          end
        endcase
      end
    end

    if (cmd.pop_step) begin
      q_we     = 1'b1;
      q_tail   = tail_adv;
      q_fill   = cur_fill - 1'b1;
      rd_addr  = {qi, tail_adv};
      emit     = 1'b1;
      e_data   = rd_data;
      e_level  = cur_fill - 1'b1;
      e_last   = stat.pop_last;
    end
  end

  // Byte memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_mem[{qi, cur_head}] <= din_q;
    end
    rd_data <= byte_mem[rd_addr];
  end

  // Queue control state, free search result and pop counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mqbr_pkg::NUM_QUEUES; i++) begin
        in_use[i]   <= 1'b0;
        head_ptr[i] <= '0;
        tail_ptr[i] <= '0;
        fill_cnt[i] <= '0;
      end
      free_idx <= '0;
      free_any <= 1'b1;
      remain   <= '0;
    end else begin
      if (q_we) begin
        in_use[q_idx]   <= q_used;
        head_ptr[q_idx] <= q_head;
        tail_ptr[q_idx] <= q_tail;
        fill_cnt[q_idx] <= q_fill;
      end
      free_idx <= free_idx_next;
      free_any <= free_any_next;
      if (cmd.pop_start) begin
        remain <= pop_n;
      end else if (cmd.pop_step) begin
        remain <= remain - 1'b1;
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      data_out     <= e_data;
      status       <= e_status;
      endpoint_out <= e_ep;
      level        <= e_level;
      last         <= e_last;
    end
  end

endmodule

@@ rtl/multi_queue_byte_ring_engine_top.sv @@
// Multi-queue byte ring engine: 32 byte rings of 4096 bytes, each opened, pushed, popped
// and closed through one item channel, with results on a registered output channel.
// Push, open, close, and any access that ends in an empty, full or invalid status present
// their single result once the item is captured and the output register is free, and hold
// the item channel until it is loaded. A pop reads its first byte through the registered
// read port, then presents one byte per cycle while the output register is free, as the
// byte memory has a single read port, and holds the item channel until its last byte is
// loaded. One item is worked on at a time; the next item is accepted in the cycle after
// the previous one has put its last result into the output register, later while that
// register is full and not taken. The byte memory is not cleared after reset and needs
// no clearing pass; queue pointers, fill counts and in-use marks are cleared by reset.
module multi_queue_byte_ring_engine_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [mqbr_pkg::ACT_W-1:0]    action,
  input  logic [mqbr_pkg::EP_W-1:0]     endpoint,
  input  logic [mqbr_pkg::BYTE_W-1:0]   data_in,
  input  logic [mqbr_pkg::REQ_W-1:0]    request_len,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [mqbr_pkg::BYTE_W-1:0]   data_out,
  output logic [mqbr_pkg::STAT_W-1:0]   status,
  output logic [mqbr_pkg::EP_W-1:0]     endpoint_out,
  output logic [mqbr_pkg::FILL_W-1:0]   level,
  output logic                          last
);

  mqbr_pkg::cmd_t  cmd;
  mqbr_pkg::stat_t stat;

  // Sequencer.
  mqbr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Queue state, byte memory and output register.
  mqbr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (action),
    .endpoint     (endpoint),
    .data_in      (data_in),
    .request_len  (request_len),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .data_out     (data_out),
    .status       (status),
    .endpoint_out (endpoint_out),
    .level        (level),
    .last         (last)
  );

`ifndef NO_ASSERTIONS
  // Items are worked one at a time, so a transfer is never followed at once by another.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted in the cycle after a transfer");

  // Only popped bytes can be non-final results, and they always carry an ok status.
  a_nonlast_is_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> status == mqbr_pkg::ST_OK)
    else $error("non-final result with a status other than ok");

  // Invalid, empty and no-free results report a level of zero.
  a_err_level_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == mqbr_pkg::ST_INVALID || status == mqbr_pkg::ST_EMPTY ||
                     status == mqbr_pkg::ST_NOFREE) |-> level == '0)
    else $error("error result with a nonzero level");

  // A full drop reports the full ring size.
  a_full_level: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == mqbr_pkg::ST_FULL |->
      level == mqbr_pkg::FILL_W'(mqbr_pkg::QUEUE_BYTES))
    else $error("full status without a full level");
`endif

endmodule
